// ----- rtl/pwcs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pwcs_pkg
// Shared sizes, status codes and types for the priority wait semaphore.
// ---------------------------------------------------------------------------
package pwcs_pkg;

   // Queue depth and field sizes
   localparam int unsigned WAIT_DEPTH    = 16;
   localparam int unsigned COUNT_MAX     = 65535;
   localparam int unsigned TASK_BITS     = 8;
   localparam int unsigned PRIORITY_BITS = 8;

   // Port widths
   localparam int unsigned TASK_W    = 8;
   localparam int unsigned PRIO_W    = 8;
   localparam int unsigned COUNT_W   = 16;
   localparam int unsigned STATUS_W  = 3;
   localparam int unsigned WAITERS_W = 5;

   // Derived sizes
   localparam int unsigned IDX_BITS  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
   localparam int unsigned PAD_DEPTH = 1 << IDX_BITS;
   localparam int unsigned FILL_BITS = $clog2(WAIT_DEPTH + 1);

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_TOOK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BLOCKED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_COUNTED   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_HANDOFF   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_REJECTED  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;
   localparam logic [STATUS_W-1:0] ST_SATURATED = 3'd6;

   // Opcodes
   localparam logic OP_WAIT   = 1'b0;
   localparam logic OP_SIGNAL = 1'b1;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;   // latch request and best waiter
      logic commit;    // apply operation, register result
   } cmd_type;

   // Node of the min-priority search tree
   typedef struct packed {
      logic                     valid;
      logic [PRIORITY_BITS-1:0] prio;
      logic [IDX_BITS-1:0]      idx;
   } node_type;

endpackage : pwcs_pkg
`default_nettype wire

// ----- rtl/pwcs_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pwcs_ctrl
// Two-state sequencer: accept a word, then commit it in the datapath.
// ---------------------------------------------------------------------------
module pwcs_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   output pwcs_pkg::cmd_type     cmd
);
   import pwcs_pkg::*;

   localparam logic S_IDLE   = 1'b0;
   localparam logic S_COMMIT = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      cmd         = '0;
      state_in    = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff == S_COMMIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule : pwcs_ctrl
`default_nettype wire

// ----- rtl/pwcs_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pwcs_dp
// Token counter, wait queue, min-priority search tree and result register.
// ---------------------------------------------------------------------------
module pwcs_dp (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire pwcs_pkg::cmd_type               cmd,
   input  wire logic                            req_opcode,
   input  wire logic [pwcs_pkg::TASK_W-1:0]     req_task_id,
   input  wire logic [pwcs_pkg::PRIO_W-1:0]     req_task_priority,
   input  wire logic                            req_from_isr,
   input  wire logic                            req_task_present,
   input  wire logic                            csr_we,
   input  wire logic [pwcs_pkg::COUNT_W-1:0]    csr_wdata,
   output logic                                 rsp_valid,
   output logic [pwcs_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                 rsp_woken_valid,
   output logic [pwcs_pkg::TASK_W-1:0]          rsp_woken_task,
   output logic [pwcs_pkg::COUNT_W-1:0]         rsp_token_count,
   output logic [pwcs_pkg::WAITERS_W-1:0]       rsp_waiters
);
   import pwcs_pkg::*;

   // Semaphore state
   logic [COUNT_W-1:0]       tokens_ff, tokens_in;
   logic [FILL_BITS-1:0]     fill_ff, fill_in;
   logic [TASK_BITS-1:0]     q_task_ff [WAIT_DEPTH];
   logic [TASK_BITS-1:0]     q_task_in [WAIT_DEPTH];
   logic [PRIORITY_BITS-1:0] q_prio_ff [WAIT_DEPTH];
   logic [PRIORITY_BITS-1:0] q_prio_in [WAIT_DEPTH];

   // Latched request
   logic                     op_ff;
   logic [TASK_BITS-1:0]     tid_ff;
   logic [PRIORITY_BITS-1:0] prio_ff;
   logic                     reject_ff;
   logic [IDX_BITS-1:0]      best_ff;

   // Result register
   logic                     rv_ff;
   logic [STATUS_W-1:0]      status_ff, status_in;
   logic                     wv_ff, wv_in;
   logic [TASK_W-1:0]        wtask_ff, wtask_in;

   node_type                 tree [2*PAD_DEPTH];

   // Min search: heap-ordered tree, left child is the older entry so ties
   // keep the oldest waiter.
   always_comb begin
      tree[0] = '0;
      for (int i = 0; i < WAIT_DEPTH; i++) begin
         tree[PAD_DEPTH+i].valid = (i < int'(fill_ff));
         tree[PAD_DEPTH+i].prio  = q_prio_ff[i];
         tree[PAD_DEPTH+i].idx   = IDX_BITS'(i);
      end
      for (int i = WAIT_DEPTH; i < PAD_DEPTH; i++) begin
         tree[PAD_DEPTH+i] = '0;
      end
      for (int k = PAD_DEPTH - 1; k >= 1; k--) begin
         if (!tree[2*k].valid) begin
            tree[k] = tree[2*k+1];
         end else if (tree[2*k+1].valid && (tree[2*k+1].prio < tree[2*k].prio)) begin
            tree[k] = tree[2*k+1];
         end else begin
            tree[k] = tree[2*k];
         end
      end
   end

   // Operation decode and state update
   always_comb begin
      logic has_token;
      logic q_full;
      logic q_empty;
      logic cnt_max;
      logic do_block;
      logic do_handoff;

      has_token  = (tokens_ff != '0);
      q_full     = (int'(fill_ff) >= WAIT_DEPTH);
      q_empty    = (fill_ff == '0);
      cnt_max    = ({16'd0, tokens_ff} >= 32'(COUNT_MAX));
      do_block   = 1'b0;
      do_handoff = 1'b0;

      tokens_in = tokens_ff;
      fill_in   = fill_ff;
      status_in = status_ff;
      wv_in     = 1'b0;
      wtask_in  = '0;

      if (op_ff == OP_WAIT) begin
         if (reject_ff) begin
            status_in = ST_REJECTED;
         end else if (has_token) begin
            tokens_in = tokens_ff - 1'b1;
            status_in = ST_TOOK;
         end else if (!q_full) begin
            do_block  = 1'b1;
            fill_in   = fill_ff + 1'b1;
            status_in = ST_BLOCKED;
         end else begin
            status_in = ST_FULL;
         end
      end else begin
         if (!q_empty) begin
            do_handoff = 1'b1;
            wv_in      = 1'b1;
            wtask_in   = TASK_W'(q_task_ff[best_ff]);
            fill_in    = fill_ff - 1'b1;
            status_in  = ST_HANDOFF;
         end else if (!cnt_max) begin
            tokens_in = tokens_ff + 1'b1;
            status_in = ST_COUNTED;
         end else begin
            status_in = ST_SATURATED;
         end
      end

      // Queue: append at fill, or close up behind the removed waiter
      for (int i = 0; i < WAIT_DEPTH; i++) begin
         q_task_in[i] = q_task_ff[i];
         q_prio_in[i] = q_prio_ff[i];
         if (do_block && (IDX_BITS'(i) == fill_ff[IDX_BITS-1:0])) begin
            q_task_in[i] = tid_ff;
            q_prio_in[i] = prio_ff;
         end else if (do_handoff && (i < WAIT_DEPTH - 1) && (IDX_BITS'(i) >= best_ff)) begin
            q_task_in[i] = q_task_ff[(i + 1) % WAIT_DEPTH];
            q_prio_in[i] = q_prio_ff[(i + 1) % WAIT_DEPTH];
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         tokens_ff <= '0;
         fill_ff   <= '0;
         rv_ff     <= 1'b0;
      end else begin
         rv_ff <= cmd.commit;
         if (csr_we) begin
            tokens_ff <= ({16'd0, csr_wdata} > 32'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                               : csr_wdata;
            fill_ff   <= '0;
         end else if (cmd.commit) begin
            tokens_ff <= tokens_in;
            fill_ff   <= fill_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_opcode;
         tid_ff    <= req_task_id[TASK_BITS-1:0];
         prio_ff   <= req_task_priority[PRIORITY_BITS-1:0];
         reject_ff <= req_from_isr || !req_task_present;
         best_ff   <= tree[1].idx;
      end
      if (cmd.commit) begin
         status_ff <= status_in;
         wv_ff     <= wv_in;
         wtask_ff  <= wtask_in;
         for (int i = 0; i < WAIT_DEPTH; i++) begin
            q_task_ff[i] <= q_task_in[i];
            q_prio_ff[i] <= q_prio_in[i];
         end
      end
   end

   assign rsp_valid       = rv_ff;
   assign rsp_status      = status_ff;
   assign rsp_woken_valid = wv_ff;
   assign rsp_woken_task  = wtask_ff;
   assign rsp_token_count = tokens_ff;
   assign rsp_waiters     = WAITERS_W'(fill_ff);

endmodule : pwcs_dp
`default_nettype wire

// ----- rtl/priority_wait_counting_semaphore_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// priority_wait_counting_semaphore_top
// Counting semaphore with a 16-entry wait queue served in priority order.
// ---------------------------------------------------------------------------
//
//  Channel   Handshake            Word
//  -------   ------------------   ------------------------------------------
//  request   start / busy         opcode, task id, priority, isr, present
//  response  rsp_valid (strobe)   status, woken task, token count, waiters
//  csr       csr_we               initial_count (16 bits)
//
//  A word is taken at an edge with start high and busy low. busy then
//  stays high for one cycle while the word is committed; the response
//  strobe follows in the next cycle, the same cycle in which the next word
//  may be taken. No word is accepted while one is in flight: the
//  min-priority search (taken at accept), then the queue update (commit
//  cycle). Reset is synchronous: token count 0, queue empty. A csr write
//  reloads the count (capped at the maximum) and empties the queue. The
//  response side cannot stall; each response shows for exactly one cycle.
//
module priority_wait_counting_semaphore_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic                            req_opcode,
   input  wire logic [pwcs_pkg::TASK_W-1:0]     req_task_id,
   input  wire logic [pwcs_pkg::PRIO_W-1:0]     req_task_priority,
   input  wire logic                            req_from_isr,
   input  wire logic                            req_task_present,
   // response
   output logic                                 rsp_valid,
   output logic [pwcs_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                 rsp_woken_valid,
   output logic [pwcs_pkg::TASK_W-1:0]          rsp_woken_task,
   output logic [pwcs_pkg::COUNT_W-1:0]         rsp_token_count,
   output logic [pwcs_pkg::WAITERS_W-1:0]       rsp_waiters,
   // configuration
   input  wire logic                            csr_we,
   input  wire logic [pwcs_pkg::COUNT_W-1:0]    csr_wdata
);
   import pwcs_pkg::*;

   cmd_type cmd;

   // Sequencer: capture on accept, commit on the following cycle
   pwcs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // Count, queue, search tree and response register
   pwcs_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_opcode        (req_opcode),
      .req_task_id       (req_task_id),
      .req_task_priority (req_task_priority),
      .req_from_isr      (req_from_isr),
      .req_task_present  (req_task_present),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_woken_valid   (rsp_woken_valid),
      .rsp_woken_task    (rsp_woken_task),
      .rsp_token_count   (rsp_token_count),
      .rsp_waiters       (rsp_waiters)
   );

endmodule : priority_wait_counting_semaphore_top
`default_nettype wire

// ----- rtl/pwcs_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pwcs_checker
// Port-level checks on request/response timing and response consistency.
// ---------------------------------------------------------------------------
module pwcs_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            start,
   input wire logic                            busy,
   input wire logic                            rsp_valid,
   input wire logic [pwcs_pkg::STATUS_W-1:0]   rsp_status,
   input wire logic                            rsp_woken_valid,
   input wire logic [pwcs_pkg::WAITERS_W-1:0]  rsp_waiters
);
   import pwcs_pkg::*;

   // accepted word raises busy in the next cycle, holding off the next one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   // response strobe follows its accept through the commit state and the response register
   a_rsp_timing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("response without matching accept");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_woken_handoff: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_woken_valid == (rsp_status == ST_HANDOFF)))
      else $error("woken flag disagrees with status");

   a_waiters_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_waiters) <= WAIT_DEPTH))
      else $error("waiter count above queue depth");

endmodule : pwcs_checker

bind priority_wait_counting_semaphore_top pwcs_checker u_pwcs_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_woken_valid (rsp_woken_valid),
   .rsp_waiters     (rsp_waiters)
);
`default_nettype wire
